[rtl/core/circular_server_dispatcher_unit_macros.svh]
// Assertion macros for the checker file of the dispatcher.
`ifndef CIRCULAR_SERVER_DISPATCHER_UNIT_MACROS_SVH
`define CIRCULAR_SERVER_DISPATCHER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSD_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/csd_pkg.sv]
`default_nettype none

package csd_pkg;

    // Built server limit and default build size.
    localparam int MAX_SERVERS     = 16;
    localparam int NUM_SERVERS_DEF = 16;

    // Field widths.
    localparam int T_W    = 30;
    localparam int BUSY_W = 31;
    localparam int CNT_W  = 20;
    localparam int K_W    = 5;
    localparam int SRV_W  = 4;

    // Stream data widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_FIELD_W = SRV_W + 1 + CNT_W;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // Handled-count saturation value.
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Server count register value after reset.
    localparam logic [K_W-1:0] SERVER_COUNT_RST = 5'd16;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Result kinds.
    localparam logic KIND_ASSIGN = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // One request item after classification.
    typedef struct packed {
        logic [T_W-1:0] arrival;
        logic [T_W-1:0] load;
        logic           last;
    } t_req_item;

    // One result item.
    typedef struct packed {
        logic             kind;
        logic [SRV_W-1:0] srv;
        logic             dropped;
        logic [CNT_W-1:0] count;
        logic             last;
    } t_result;

    // Back end sequencing.
    typedef enum logic [1:0] {
        ST_RUN,
        ST_SCAN,
        ST_REPORT
    } t_back_state;

endpackage

`default_nettype wire

[rtl/core/circular_server_dispatcher_unit.sv]
// Circular server dispatcher.
// Requests enter on the s_axis channel: tdata holds arrival_time in bits 29:0
// and load_time in bits 59:30, tlast marks the final request of a batch.
// Results leave on the m_axis channel, one assignment item per request, and
// after a final request one report item per busiest server in ascending order.
// The server count register is written through i_cfg_valid / i_cfg_data and
// is always ready; write it only while no request is in flight.
// An assignment item is registered: its request passes through the request
// queue and then the output register before it is presented. The back end
// dispatches one request per cycle while the output is free, set by the
// combinational busy-timer compare and circular pick. A final request adds
// a count scan over the K active servers plus the report output, K being
// the active server count, during which no request is dispatched.
// Reset clears all timers and counts, sets the start pointer to server 0 and
// the server count to 16. When m_axis_tready is low the output item holds,
// the two-entry request queue fills and s_axis_tready drops.
`default_nettype none

module circular_server_dispatcher_unit #(
    parameter int NUM_SERVERS = csd_pkg::NUM_SERVERS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Configuration write channel.
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [csd_pkg::K_W-1:0]         i_cfg_data,
    // Request stream.
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [29:0] arrival_time, [59:30] load_time, [63:60] zero
    input  wire logic [csd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                            s_axis_tlast,
    // Result stream.
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [3:0] server_index, [4] dropped, [24:5] handled_count, [31:25] zero
    output logic [csd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // [0] result_kind
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast
);
    import csd_pkg::*;

    logic [K_W-1:0] r_server_count;
    logic           req_valid;
    t_req_item      req;
    logic           req_pop;
    t_result        res;

    // Server count register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_count <= SERVER_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_server_count <= i_cfg_data;
        end
    end

    // Front end: takes and classifies requests into the queue.
    csd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_req_pop   (req_pop)
    );

    // Back end: dispatch and busiest-server report.
    csd_back #(
        .NUM_SERVERS (NUM_SERVERS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_server_count (r_server_count),
        .i_req_valid    (req_valid),
        .i_req          (req),
        .o_req_pop      (req_pop),
        .o_res_valid    (m_axis_tvalid),
        .o_res          (res),
        .i_res_ready    (m_axis_tready)
    );

    // Pack the result item onto the stream.
    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res.count, res.dropped, res.srv};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

[rtl/core/csd_front.sv]
`default_nettype none

module csd_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [csd_pkg::IN_TDATA_W-1:0] i_data,
    input  wire logic                         i_last,
    output logic                              o_req_valid,
    output csd_pkg::t_req_item                o_req,
    input  wire logic                         i_req_pop
);
    import csd_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    t_req_item           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [FILL_W-1:0]   r_fill;
    logic [FILL_W-1:0]   n_fill;
    t_req_item           req_in;
    logic                push;
    logic                pop;

    // Split the incoming item into its fields; the upper pad bits are ignored.
    always_comb begin
        req_in.arrival = i_data[T_W-1:0];
        req_in.load    = i_data[2*T_W-1:T_W];
        req_in.last    = i_last;
    end

    // Queue handshakes.
    assign o_ready     = (r_fill != FILL_W'(QUEUE_DEPTH));
    assign o_req_valid = (r_fill != '0);
    assign o_req       = r_mem[r_rd_ptr];
    assign push        = i_valid && o_ready;
    assign pop         = i_req_pop && o_req_valid;

    // Fill level follows pushes and pops.
    always_comb begin
        n_fill = r_fill;
        if (push && !pop) begin
            n_fill = r_fill + FILL_W'(1);
        end else if (pop && !push) begin
            n_fill = r_fill - FILL_W'(1);
        end
    end

    // Pointer and fill registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_fill <= n_fill;
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= req_in;
        end
    end

endmodule

`default_nettype wire

[rtl/core/csd_back.sv]
`default_nettype none

module csd_back #(
    parameter int NUM_SERVERS = csd_pkg::NUM_SERVERS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [csd_pkg::K_W-1:0] i_server_count,
    input  wire logic                  i_req_valid,
    input  csd_pkg::t_req_item         i_req,
    output logic                       o_req_pop,
    output logic                       o_res_valid,
    output csd_pkg::t_result           o_res,
    input  wire logic                  i_res_ready
);
    import csd_pkg::*;

    localparam int NS_EFF = (NUM_SERVERS < MAX_SERVERS) ? NUM_SERVERS : MAX_SERVERS;
    localparam int IDX_W  = (NS_EFF > 1) ? $clog2(NS_EFF) : 1;

    // Per-server timers and counts.
    logic [BUSY_W-1:0] r_busy  [NS_EFF];
    logic [CNT_W-1:0]  r_count [NS_EFF];

    t_back_state       r_state;
    t_back_state       n_state;
    logic [IDX_W-1:0]  r_sp;
    logic [IDX_W-1:0]  n_sp;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;
    logic [CNT_W-1:0]  r_max;
    logic [CNT_W-1:0]  n_max;
    logic [IDX_W-1:0]  r_last_srv;
    logic [IDX_W-1:0]  n_last_srv;
    logic              r_res_valid;
    logic              n_res_valid;
    t_result           r_res;
    t_result           n_res;

    logic [K_W-1:0]    k_eff;
    logic [IDX_W-1:0]  start;
    logic [NS_EFF-1:0] free_vec;
    logic [NS_EFF-1:0] hi_vec;
    logic [NS_EFF-1:0] pick_vec;
    logic              found;
    logic [IDX_W-1:0]  sel;
    logic [IDX_W-1:0]  rd_addr;
    logic [CNT_W-1:0]  rd_cnt;
    logic [CNT_W-1:0]  cnt_inc;
    logic [BUSY_W-1:0] busy_sum;
    logic [K_W-1:0]    start_inc;
    logic              last_scan;
    logic              out_free;
    logic              upd;
    logic              clr;

    // Clamp the server count to 1 .. built count.
    always_comb begin
        if (i_server_count == '0) begin
            k_eff = K_W'(1);
        end else if (i_server_count > K_W'(NS_EFF)) begin
            k_eff = K_W'(NS_EFF);
        end else begin
            k_eff = i_server_count;
        end
    end

    // A stale start pointer beyond the active range restarts at server 0.
    assign start = (K_W'(r_sp) < k_eff) ? r_sp : '0;

    // Free servers, and those at or after the start point.
    always_comb begin
        for (int s = 0; s < NS_EFF; s++) begin
            free_vec[s] = (K_W'(s) < k_eff) && (r_busy[s] <= {1'b0, i_req.arrival});
            hi_vec[s]   = free_vec[s] && (IDX_W'(s) >= start);
        end
    end

    // Circular priority pick: first free at or after start, else first free.
    assign found    = |free_vec;
    assign pick_vec = (|hi_vec) ? hi_vec : free_vec;

    always_comb begin
        sel = '0;
        for (int s = NS_EFF - 1; s >= 0; s--) begin
            if (pick_vec[s]) begin
                sel = IDX_W'(s);
            end
        end
    end

    // Shared count read port: chosen server while running, scan index otherwise.
    assign rd_addr   = (r_state == ST_RUN) ? sel : r_idx;
    assign rd_cnt    = r_count[rd_addr];
    assign cnt_inc   = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + CNT_W'(1);
    assign busy_sum  = {1'b0, i_req.arrival} + {1'b0, i_req.load};
    assign start_inc = K_W'(start) + K_W'(1);
    assign last_scan = (K_W'(r_idx) == k_eff - K_W'(1));
    assign out_free  = !r_res_valid || i_res_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RUN: begin
                if (i_req_valid && out_free && i_req.last) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_scan) begin
                    n_state = ST_REPORT;
                end
            end
            ST_REPORT: begin
                if (out_free && (r_idx == r_last_srv)) begin
                    n_state = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    // Datapath controls and result loading.
    always_comb begin
        o_req_pop   = 1'b0;
        upd         = 1'b0;
        clr         = 1'b0;
        n_sp        = r_sp;
        n_idx       = r_idx;
        n_max       = r_max;
        n_last_srv  = r_last_srv;
        n_res_valid = r_res_valid && !i_res_ready;
        n_res       = r_res;
        case (r_state)
            ST_RUN: begin
                n_idx      = '0;
                n_max      = '0;
                n_last_srv = '0;
                if (i_req_valid && out_free) begin
                    o_req_pop   = 1'b1;
                    upd         = found;
                    n_sp        = (start_inc >= k_eff) ? '0 : start_inc[IDX_W-1:0];
                    n_res_valid = 1'b1;
                    n_res.kind  = KIND_ASSIGN;
                    n_res.last  = !i_req.last;
                    if (found) begin
                        n_res.srv     = SRV_W'(sel);
                        n_res.dropped = 1'b0;
                        n_res.count   = cnt_inc;
                    end else begin
                        n_res.srv     = '0;
                        n_res.dropped = 1'b1;
                        n_res.count   = '0;
                    end
                end
            end
            ST_SCAN: begin
                // Running maximum and the highest index that holds it.
                if (rd_cnt > r_max) begin
                    n_max      = rd_cnt;
                    n_last_srv = r_idx;
                end else if (rd_cnt == r_max) begin
                    n_last_srv = r_idx;
                end
                n_idx = last_scan ? '0 : r_idx + IDX_W'(1);
            end
            ST_REPORT: begin
                if (out_free) begin
                    if (rd_cnt == r_max) begin
                        n_res_valid   = 1'b1;
                        n_res.kind    = KIND_REPORT;
                        n_res.srv     = SRV_W'(r_idx);
                        n_res.dropped = 1'b0;
                        n_res.count   = rd_cnt;
                        n_res.last    = (r_idx == r_last_srv);
                    end
                    n_idx = r_idx + IDX_W'(1);
                    if (r_idx == r_last_srv) begin
                        clr  = 1'b1;
                        n_sp = '0;
                    end
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    // Control state and server state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_res_valid <= 1'b0;
            r_sp        <= '0;
            for (int s = 0; s < NS_EFF; s++) begin
                r_busy[s]  <= '0;
                r_count[s] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            r_sp        <= n_sp;
            if (clr) begin
                for (int s = 0; s < NS_EFF; s++) begin
                    r_busy[s]  <= '0;
                    r_count[s] <= '0;
                end
            end else if (upd) begin
                r_busy[sel]  <= busy_sum;
                r_count[sel] <= cnt_inc;
            end
        end
    end

    // Scan registers and the output register.
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_max      <= n_max;
        r_last_srv <= n_last_srv;
        r_res      <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

[rtl/core/csd_checker.sv]
`default_nettype none
`include "circular_server_dispatcher_unit_macros.svh"

module csd_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_cfg_valid,
    input wire logic                            o_cfg_ready,
    input wire logic [csd_pkg::K_W-1:0]         i_cfg_data,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic [csd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input wire logic                            s_axis_tlast,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [csd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                            m_axis_tuser,
    input wire logic                            m_axis_tlast
);
    import csd_pkg::*;

    logic             out_dropped;
    logic [SRV_W-1:0] out_srv;
    logic [CNT_W-1:0] out_count;
    logic             cfg_seen;
    logic             in_seen;

    assign out_srv     = m_axis_tdata[SRV_W-1:0];
    assign out_dropped = m_axis_tdata[SRV_W];
    assign out_count   = m_axis_tdata[OUT_FIELD_W-1:SRV_W+1];
    assign cfg_seen    = i_cfg_valid && o_cfg_ready && (i_cfg_data != '0);
    assign in_seen     = s_axis_tvalid && s_axis_tready && s_axis_tlast && (s_axis_tdata != '0);

    // A stalled result item holds still.
    `CSD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result item changed while stalled")

    // Report entries never carry the dropped flag.
    `CSD_ASSERT_NOW(a_report_not_dropped, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == KIND_REPORT), !out_dropped, "report entry marked dropped")

    // A dropped request reports server 0 with a zero count.
    `CSD_ASSERT_NOW(a_drop_fields, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == KIND_ASSIGN) && out_dropped, (out_srv == '0) && (out_count == '0), "dropped result has nonzero fields")

    // A served request always leaves its server with a nonzero count.
    `CSD_ASSERT_NOW(a_served_count, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == KIND_ASSIGN) && !out_dropped && (cfg_seen || in_seen || 1'b1), out_count != '0, "served request with zero count")

endmodule

bind circular_server_dispatcher_unit csd_checker u_csd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready),
    .i_cfg_data    (i_cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

[dv/tb_top.sv]
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import csd_pkg::*;

    // Run limits and pacing.
    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_SETTLE  = 48;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_ITEMS  = 265;
    localparam int BUILT_SERVERS = (NUM_SERVERS_DEF < MAX_SERVERS) ? NUM_SERVERS_DEF
                                                                   : MAX_SERVERS;
    localparam int unsigned T_MAX = (1 << T_W) - 1;

    // Receiver stall patterns.
    typedef enum int {
        RX_STEADY,
        RX_SPARSE_STALL,
        RX_HEAVY_STALL
    } t_rx_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [K_W-1:0]         i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;

    // Mirror of the dispatcher state.
    logic [BUSY_W-1:0] srv_busy_until [MAX_SERVERS];
    logic [CNT_W-1:0]  srv_handled [MAX_SERVERS];
    logic [SRV_W-1:0]  next_start;
    logic [K_W-1:0]    server_count_reg;

    // Results still owed by the dispatcher, oldest first.
    t_result due_results [$];
    int      mismatch_count = 0;

    // Pacing controls shared by the sender, the receiver and the tests.
    bit free_flow = 1'b0;
    int rx_hold_cycles = 0;
    int burst_left = 0;

    circular_server_dispatcher_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Free-running clock.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Server count actually in effect, clamped to the built range.
    function automatic int active_servers();
        int k;
        k = int'(server_count_reg);
        if (k < 1) begin
            k = 1;
        end
        if (k > BUILT_SERVERS) begin
            k = BUILT_SERVERS;
        end
        return k;
    endfunction

    // Return every server to idle with a cleared count.
    function automatic void clear_servers();
        int j;
        for (j = 0; j < MAX_SERVERS; j++) begin
            srv_busy_until[j] = '0;
            srv_handled[j] = '0;
        end
        next_start = '0;
    endfunction

    // Dispatch one request in the mirror and queue the results it owes.
    function automatic void predict_dispatch(input logic [T_W-1:0] arrival,
                                             input logic [T_W-1:0] load,
                                             input logic final_req);
        int k;
        int first;
        int idx;
        int pick;
        int j;
        int busiest_last;
        bit found;
        logic [CNT_W-1:0] peak;
        t_result r;
        k = active_servers();
        first = (int'(next_start) < k) ? int'(next_start) : 0;
        found = 1'b0;
        pick = 0;
        // Circular search for the first server whose timer has expired.
        for (j = 0; j < k; j++) begin
            idx = (first + j) % k;
            if (!found && srv_busy_until[idx] <= {1'b0, arrival}) begin
                pick = idx;
                found = 1'b1;
            end
        end
        r.kind = KIND_ASSIGN;
        r.last = !final_req;
        if (found) begin
            srv_busy_until[pick] = {1'b0, arrival} + {1'b0, load};
            if (srv_handled[pick] != COUNT_MAX) begin
                srv_handled[pick] = srv_handled[pick] + 1'b1;
            end
            r.srv = SRV_W'(pick);
            r.dropped = 1'b0;
            r.count = srv_handled[pick];
        end else begin
            r.srv = '0;
            r.dropped = 1'b1;
            r.count = '0;
        end
        due_results.insert(due_results.size(), r);
        next_start = (first + 1 >= k) ? '0 : SRV_W'(first + 1);

        // A final request reports every busiest server and ends the batch.
        if (final_req) begin
            peak = '0;
            busiest_last = 0;
            for (j = 0; j < k; j++) begin
                if (srv_handled[j] > peak) begin
                    peak = srv_handled[j];
                end
            end
            for (j = 0; j < k; j++) begin
                if (srv_handled[j] == peak) begin
                    busiest_last = j;
                end
            end
            for (j = 0; j < k; j++) begin
                if (srv_handled[j] == peak) begin
                    r.kind = KIND_REPORT;
                    r.srv = SRV_W'(j);
                    r.dropped = 1'b0;
                    r.count = peak;
                    r.last = (j == busiest_last);
                    due_results.insert(due_results.size(), r);
                end
            end
            clear_servers();
        end
    endfunction

    // Offer one request, honoring the burst and gap pattern, and predict it once taken.
    task automatic send_request(input logic [T_W-1:0] arrival, input logic [T_W-1:0] load,
                                input logic final_req);
        int gap;
        gap = 0;
        if (!free_flow) begin
            if (burst_left == 0) begin
                gap = $urandom_range(0, 6);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_TDATA_W - 2 * T_W){1'b0}}, load, arrival};
        s_axis_tlast <= final_req;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        predict_dispatch(arrival, load, final_req);
    endtask

    // Stop offering and wait until every owed result has come and the block has settled.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_SETTLE) @(posedge i_clk);
    endtask

    // Write the server count register; only called while the block is idle.
    task automatic write_server_count(input logic [K_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        server_count_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Reset default of sixteen servers, field extremes and a decreasing arrival.
    task automatic test_default_count();
        send_request('0, 30'd1, 1'b0);
        send_request('0, 30'd1, 1'b0);
        send_request(T_W'(T_MAX), T_W'(T_MAX), 1'b0);
        send_request(30'd5, 30'd3, 1'b1);
        drain_results();
    endtask

    // Out-of-range register values clamp to one server or to the built count.
    task automatic test_register_range();
        write_server_count('0);
        send_request(30'd10, 30'd5, 1'b0);
        send_request(30'd12, 30'd5, 1'b0);
        send_request(30'd15, 30'd1, 1'b1);
        drain_results();
        write_server_count(5'h1F);
        send_request(30'd7, 30'h2AAAAAAA, 1'b0);
        send_request(30'd7, 30'h15555555, 1'b0);
        send_request(30'd8, 30'd2, 1'b1);
        drain_results();
    endtask

    // Every server busy forces a drop; equal counts all appear in the report.
    task automatic test_drops_and_ties();
        write_server_count(5'd3);
        send_request(30'd100, 30'd1000, 1'b0);
        send_request(30'd100, 30'd1000, 1'b0);
        send_request(30'd100, 30'd1000, 1'b0);
        send_request(30'd200, 30'd10, 1'b0);
        send_request(30'd1100, 30'd5, 1'b0);
        send_request(30'd1100, 30'd5, 1'b1);
        drain_results();
    endtask

    // Shrinking the server count mid-batch restarts the search at server zero.
    task automatic test_count_change_mid_batch();
        int i;
        write_server_count(5'd16);
        for (i = 0; i < 6; i++) begin
            send_request('0, 30'd500, 1'b0);
        end
        drain_results();
        write_server_count(5'd4);
        send_request(30'd10, 30'd1, 1'b0);
        send_request(30'd500, 30'd1, 1'b0);
        send_request(30'd501, 30'd1, 1'b1);
        drain_results();
    endtask

    // One server takes every request back to back, so its count climbs each step.
    task automatic test_single_server();
        int i;
        write_server_count(5'd1);
        free_flow = 1'b1;
        for (i = 0; i < 12; i++) begin
            send_request(T_W'(i * 2), 30'd2, i == 11);
        end
        drain_results();
        free_flow = 1'b0;
    endtask

    // A long receiver hold fills the block while requests keep coming.
    task automatic test_output_backpressure();
        int i;
        write_server_count(5'd16);
        rx_hold_cycles = LONG_HOLD;
        for (i = 0; i < 24; i++) begin
            send_request(T_W'(i * 3), T_W'($urandom_range(1, 60)), i == 23);
        end
        drain_results();
    endtask

    // Random batches with loads sized to keep the servers near saturation.
    task automatic test_random_batches();
        int sent;
        int len;
        int i;
        int k;
        int step_max;
        int unsigned load_span;
        int unsigned arr;
        int unsigned ld;
        logic final_req;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            // Change the server count between some batches.
            if ($urandom_range(0, 2) == 0) begin
                drain_results();
                case ($urandom_range(0, 3))
                    0: write_server_count(K_W'($urandom_range(0, 31)));
                    1: write_server_count(5'd1);
                    2: write_server_count(5'd16);
                    default: write_server_count(K_W'($urandom_range(2, 15)));
                endcase
            end
            k = active_servers();
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 24);
            step_max = $urandom_range(1, 50);
            load_span = step_max * k * $urandom_range(1, 3);
            arr = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1000)
                                              : $urandom_range(0, T_MAX - 4000);
            for (i = 0; i < len; i++) begin
                // Arrival mostly climbs, now and then steps back.
                if ($urandom_range(0, 19) == 0) begin
                    arr = $urandom_range(0, arr);
                end else begin
                    arr = arr + $urandom_range(0, step_max);
                    if (arr > T_MAX) begin
                        arr = T_MAX;
                    end
                end
                case ($urandom_range(0, 15))
                    0: ld = $urandom_range(1, T_MAX);
                    1: ld = T_MAX;
                    default: ld = $urandom_range(1, load_span);
                endcase
                final_req = (i == len - 1) && ($urandom_range(0, 9) != 0);
                send_request(T_W'(arr), T_W'(ld), final_req);
                sent++;
            end
        end
        drain_results();
    endtask

    // Receiver: a long hold when asked, otherwise stretches of steady or stalling flow.
    initial begin : result_receiver
        int hold_left;
        int mode_left;
        t_rx_mode mode;
        hold_left = 0;
        mode_left = 0;
        mode = RX_STEADY;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles != 0) begin
                hold_left = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (free_flow) begin
                m_axis_tready <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(8, 40);
                end
                mode_left--;
                case (mode)
                    RX_STEADY: m_axis_tready <= 1'b1;
                    RX_SPARSE_STALL: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 2) == 0);
                endcase
            end
        end
    end

    // Compare one result field and count a mismatch.
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Every accepted result is matched against the oldest owed one.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_results.size() == 0) begin
                $error("result item with none outstanding: tdata %h tuser %b tlast %b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                mismatch_count++;
            end else begin
                want = due_results.pop_front();
                check_field("result_kind", want.kind, m_axis_tuser);
                check_field("server_index", want.srv, m_axis_tdata[SRV_W-1:0]);
                check_field("dropped", want.dropped, m_axis_tdata[SRV_W]);
                check_field("handled_count", want.count, m_axis_tdata[SRV_W+CNT_W:SRV_W+1]);
                check_field("last_result", want.last, m_axis_tlast);
            end
        end
    end

    // Watchdog: ends the run when no channel moves an item for too long.
    initial begin : stall_watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("circular_server_dispatcher_unit test failed");
        $finish;
    end

    // Test sequence.
    initial begin
        server_count_reg = SERVER_COUNT_RST;
        clear_servers();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_count();
        test_register_range();
        test_drops_and_ties();
        test_count_change_mid_batch();
        test_single_server();
        test_output_backpressure();
        test_random_batches();

        if (mismatch_count == 0) begin
            $display("circular_server_dispatcher_unit test passed");
        end else begin
            $display("circular_server_dispatcher_unit test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

[circular_server_dispatcher_unit.f]
+incdir+rtl/core
rtl/core/csd_pkg.sv
rtl/core/csd_front.sv
rtl/core/csd_back.sv
rtl/core/circular_server_dispatcher_unit.sv
rtl/core/csd_checker.sv
dv/tb_top.sv
